[rtl/core/mcl_pkg.sv]
// Shared types, token codes and byte decode functions for the mini C lexer.
package mcl_pkg;

    localparam int LEXEME_BUFFER_DEF = 32;
    localparam int LINE_BITS_DEF     = 16;
    localparam int LINE_NUMBER_W     = 16;
    localparam int TOKEN_W           = 5;

    localparam logic [TOKEN_W-1:0] TOK_INT     = 5'd0;
    localparam logic [TOKEN_W-1:0] TOK_RETURN  = 5'd1;
    localparam logic [TOKEN_W-1:0] TOK_VOID    = 5'd2;
    localparam logic [TOKEN_W-1:0] TOK_ID      = 5'd3;
    localparam logic [TOKEN_W-1:0] TOK_NUM     = 5'd4;
    localparam logic [TOKEN_W-1:0] TOK_PLUS    = 5'd5;
    localparam logic [TOKEN_W-1:0] TOK_MINUS   = 5'd6;
    localparam logic [TOKEN_W-1:0] TOK_STAR    = 5'd7;
    localparam logic [TOKEN_W-1:0] TOK_DIV     = 5'd8;
    localparam logic [TOKEN_W-1:0] TOK_ASSIGN  = 5'd9;
    localparam logic [TOKEN_W-1:0] TOK_SEMI    = 5'd10;
    localparam logic [TOKEN_W-1:0] TOK_COMMA   = 5'd11;
    localparam logic [TOKEN_W-1:0] TOK_LPAREN  = 5'd12;
    localparam logic [TOKEN_W-1:0] TOK_RPAREN  = 5'd13;
    localparam logic [TOKEN_W-1:0] TOK_LBRACE  = 5'd14;
    localparam logic [TOKEN_W-1:0] TOK_RBRACE  = 5'd15;
    localparam logic [TOKEN_W-1:0] TOK_COMMENT = 5'd16;
    localparam logic [TOKEN_W-1:0] TOK_ERROR   = 5'd17;
    localparam logic [TOKEN_W-1:0] TOK_EOF     = 5'd18;

    localparam logic REC_TOKEN = 1'b0;
    localparam logic REC_CHAR  = 1'b1;

    localparam logic [1:0] KW_INT    = 2'd0;
    localparam logic [1:0] KW_RETURN = 2'd1;
    localparam logic [1:0] KW_VOID   = 2'd2;

    typedef enum logic [2:0] {
        M_START,
        M_ID,
        M_NUM,
        M_SLASH,
        M_COMMENT,
        M_STAR,
        M_ERROR
    } mode_t;

    typedef enum logic [2:0] {
        C_SPACE,
        C_NEWLINE,
        C_LETTER,
        C_DIGIT,
        C_SLASH,
        C_STAR,
        C_OP,
        C_OTHER
    } cls_t;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic                     record_kind;
        logic [TOKEN_W-1:0]       token_code;
        logic [LINE_NUMBER_W-1:0] line_number;
        logic [7:0]               text_char;
        logic                     text_last;
        logic                     run_last;
    } out_word_t;

    // datapath -> controller
    typedef struct packed {
        mode_t              mode;
        cls_t               cls;
        logic               end_flag;
        logic [TOKEN_W-1:0] flush_code;
        logic [TOKEN_W-1:0] scan_code;
        logic               char_last;
        logic               out_free;
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic               load_in;
        logic               emit;
        logic               emit_kind;
        logic [TOKEN_W-1:0] emit_code;
        logic               emit_run_last;
        logic               idx_clr;
        logic               rd;
        logic               idx_inc;
        logic               finish;
        logic               scan;
        logic               clear;
    } cmd_t;

    function automatic cls_t classify(input logic [7:0] c);
        cls_t k;
        if (c == 8'h20 || c == 8'h09 || c == 8'h0D)
            k = C_SPACE;
        else if (c == 8'h0A)
            k = C_NEWLINE;
        else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
            k = C_LETTER;
        else if (c >= "0" && c <= "9")
            k = C_DIGIT;
        else if (c == "/")
            k = C_SLASH;
        else if (c == "*")
            k = C_STAR;
        else if (c == "+" || c == "-" || c == "=" || c == ";" || c == "," ||
                 c == "(" || c == ")" || c == "{" || c == "}")
            k = C_OP;
        else
            k = C_OTHER;
        return k;
    endfunction

    function automatic logic [TOKEN_W-1:0] op_code(input logic [7:0] c);
        logic [TOKEN_W-1:0] code;
        case (c)
            "+":     code = TOK_PLUS;
            "-":     code = TOK_MINUS;
            "*":     code = TOK_STAR;
            "=":     code = TOK_ASSIGN;
            ";":     code = TOK_SEMI;
            ",":     code = TOK_COMMA;
            "(":     code = TOK_LPAREN;
            ")":     code = TOK_RPAREN;
            "{":     code = TOK_LBRACE;
            "}":     code = TOK_RBRACE;
            default: code = TOK_ERROR;
        endcase
        return code;
    endfunction

    // true when c is the keyword's character at position pos
    function automatic logic kw_hit(input logic [1:0] sel, input logic [2:0] pos,
                                    input logic [7:0] c);
        logic [7:0] want;
        want = 8'h00;
        case (sel)
            KW_INT:
            begin
                case (pos)
                    3'd0:    want = "i";
                    3'd1:    want = "n";
                    3'd2:    want = "t";
                    default: want = 8'h00;
                endcase
            end
            KW_RETURN:
            begin
                case (pos)
                    3'd0:    want = "r";
                    3'd1:    want = "e";
                    3'd2:    want = "t";
                    3'd3:    want = "u";
                    3'd4:    want = "r";
                    3'd5:    want = "n";
                    default: want = 8'h00;
                endcase
            end
            KW_VOID:
            begin
                case (pos)
                    3'd0:    want = "v";
                    3'd1:    want = "o";
                    3'd2:    want = "i";
                    3'd3:    want = "d";
                    default: want = 8'h00;
                endcase
            end
            default: want = 8'h00;
        endcase
        return (want != 8'h00) && (c == want);
    endfunction

endpackage

[rtl/core/mcl_dpath.sv]
// Lexer datapath: scan mode, lexeme memory, keyword flags, line counter, output word register.
module mcl_dpath #(
    parameter int LEXEME_BUFFER = mcl_pkg::LEXEME_BUFFER_DEF,
    parameter int LINE_BITS     = mcl_pkg::LINE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mcl_pkg::in_word_t src_word,
    output logic              tok_valid,
    input  logic              tok_stall,
    output mcl_pkg::out_word_t tok_word,
    input  mcl_pkg::cmd_t     cmd,
    output mcl_pkg::status_t  st
);

    localparam int KEEP_MAX = LEXEME_BUFFER - 1;
    localparam int LEN_W    = $clog2(LEXEME_BUFFER);
    localparam int IDX_W    = $clog2(KEEP_MAX);
    localparam int LN_W     = mcl_pkg::LINE_NUMBER_W;

    logic [7:0]           byte_reg;
    logic                 end_reg;
    mcl_pkg::mode_t       mode_reg, mode_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 kw_int_reg, kw_int_next;
    logic                 kw_ret_reg, kw_ret_next;
    logic                 kw_void_reg, kw_void_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [LEN_W-1:0]     idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    mcl_pkg::out_word_t   out_word_reg;
    mcl_pkg::out_word_t   emit_word;
    logic [7:0]           rd_data_reg;
    logic [7:0]           store [KEEP_MAX];

    mcl_pkg::cls_t        cls;
    logic [mcl_pkg::TOKEN_W-1:0] flush_code;
    logic                 char_last;
    logic                 out_free;
    logic                 line_inc;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;

    always_comb
    begin
        cls       = mcl_pkg::classify(byte_reg);
        char_last = (idx_reg + LEN_W'(1)) == len_reg;
        out_free  = !out_valid_reg || !tok_stall;
        if (mode_reg == mcl_pkg::M_NUM)
            flush_code = mcl_pkg::TOK_NUM;
        else if (len_reg == LEN_W'(3) && kw_int_reg)
            flush_code = mcl_pkg::TOK_INT;
        else if (len_reg == LEN_W'(6) && kw_ret_reg)
            flush_code = mcl_pkg::TOK_RETURN;
        else if (len_reg == LEN_W'(4) && kw_void_reg)
            flush_code = mcl_pkg::TOK_VOID;
        else
            flush_code = mcl_pkg::TOK_ID;
    end

    always_comb
    begin
        st.mode       = mode_reg;
        st.cls        = cls;
        st.end_flag   = end_reg;
        st.flush_code = flush_code;
        st.scan_code  = mcl_pkg::op_code(byte_reg);
        st.char_last  = char_last;
        st.out_free   = out_free;
    end

    // scanner state update at the end of an item
    always_comb
    begin
        mode_next    = mode_reg;
        len_next     = len_reg;
        kw_int_next  = kw_int_reg;
        kw_ret_next  = kw_ret_reg;
        kw_void_next = kw_void_reg;
        line_inc     = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = len_reg[IDX_W-1:0];
        if (cmd.clear)
        begin
            mode_next    = mcl_pkg::M_START;
            len_next     = '0;
            kw_int_next  = 1'b0;
            kw_ret_next  = 1'b0;
            kw_void_next = 1'b0;
        end
        else if (cmd.finish)
        begin
            if (cmd.scan)
            begin
                mode_next = mcl_pkg::M_START;
                len_next  = '0;
                case (cls)
                    mcl_pkg::C_NEWLINE: line_inc = 1'b1;
                    mcl_pkg::C_LETTER, mcl_pkg::C_DIGIT:
                    begin
                        mode_next    = (cls == mcl_pkg::C_LETTER) ? mcl_pkg::M_ID
                                                                 : mcl_pkg::M_NUM;
                        len_next     = LEN_W'(1);
                        wr_en        = 1'b1;
                        wr_addr      = '0;
                        kw_int_next  = mcl_pkg::kw_hit(mcl_pkg::KW_INT, 3'd0, byte_reg);
                        kw_ret_next  = mcl_pkg::kw_hit(mcl_pkg::KW_RETURN, 3'd0, byte_reg);
                        kw_void_next = mcl_pkg::kw_hit(mcl_pkg::KW_VOID, 3'd0, byte_reg);
                    end
                    mcl_pkg::C_SLASH:   mode_next = mcl_pkg::M_SLASH;
                    mcl_pkg::C_OTHER:   mode_next = mcl_pkg::M_ERROR;
                    default:            mode_next = mcl_pkg::M_START;
                endcase
            end
            else
            begin
                case (mode_reg)
                    mcl_pkg::M_ID, mcl_pkg::M_NUM:
                    begin
                        // run continues; characters past the buffer are dropped
                        if (len_reg < LEN_W'(KEEP_MAX))
                        begin
                            wr_en        = 1'b1;
                            len_next     = len_reg + LEN_W'(1);
                            kw_int_next  = kw_int_reg &&
                                mcl_pkg::kw_hit(mcl_pkg::KW_INT, len_reg[2:0], byte_reg);
                            kw_ret_next  = kw_ret_reg &&
                                mcl_pkg::kw_hit(mcl_pkg::KW_RETURN, len_reg[2:0], byte_reg);
                            kw_void_next = kw_void_reg &&
                                mcl_pkg::kw_hit(mcl_pkg::KW_VOID, len_reg[2:0], byte_reg);
                        end
                    end
                    mcl_pkg::M_SLASH:   mode_next = mcl_pkg::M_COMMENT;
                    mcl_pkg::M_COMMENT:
                    begin
                        if (cls == mcl_pkg::C_NEWLINE)
                            line_inc = 1'b1;
                        if (cls == mcl_pkg::C_STAR)
                            mode_next = mcl_pkg::M_STAR;
                    end
                    // byte after a star is taken as is
                    mcl_pkg::M_STAR:
                        mode_next = (cls == mcl_pkg::C_SLASH) ? mcl_pkg::M_START
                                                              : mcl_pkg::M_COMMENT;
                    mcl_pkg::M_ERROR:   mode_next = mcl_pkg::M_ERROR;
                    default:            mode_next = mcl_pkg::M_START;
                endcase
            end
        end
    end

    always_comb
    begin
        line_next = line_reg;
        if (cmd.clear)
            line_next = LINE_BITS'(1);
        else if (line_inc && line_reg != '1)
            line_next = line_reg + LINE_BITS'(1);
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + LEN_W'(1);
    end

    always_comb
    begin
        emit_word.record_kind = cmd.emit_kind;
        emit_word.token_code  = cmd.emit_code;
        emit_word.line_number = LN_W'(line_reg);
        emit_word.text_char   = cmd.emit_kind ? rd_data_reg : 8'h00;
        emit_word.text_last   = cmd.emit_kind && char_last;
        emit_word.run_last    = cmd.emit_run_last;
        out_valid_next        = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (!tok_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= mcl_pkg::M_START;
            len_reg       <= '0;
            kw_int_reg    <= 1'b0;
            kw_ret_reg    <= 1'b0;
            kw_void_reg   <= 1'b0;
            line_reg      <= LINE_BITS'(1);
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            len_reg       <= len_next;
            kw_int_reg    <= kw_int_next;
            kw_ret_reg    <= kw_ret_next;
            kw_void_reg   <= kw_void_next;
            line_reg      <= line_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            byte_reg <= src_word.src_byte;
            end_reg  <= src_word.end_of_text;
        end
        if (cmd.emit)
            out_word_reg <= emit_word;
    end

    // lexeme memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[wr_addr] <= byte_reg;
        if (cmd.rd)
            rd_data_reg <= store[idx_reg[IDX_W-1:0]];
    end

    assign tok_valid = out_valid_reg;
    assign tok_word  = out_word_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(KEEP_MAX))
        else $error("lexeme length beyond buffer");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == mcl_pkg::M_ERROR && !cmd.clear) |=> mode_reg == mcl_pkg::M_ERROR)
        else $error("error mode left before end of file");

    a_line_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.clear |=> line_reg >= $past(line_reg))
        else $error("line counter went backwards");

endmodule

[rtl/core/mcl_ctrl.sv]
// Lexer controller: sequences the records that one input word produces.
module mcl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             src_valid,
    output logic             src_stall,
    input  mcl_pkg::status_t st,
    output mcl_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_RDREQ,
        S_CHAR
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg;
    logic   flush_done_reg, flush_done_next;
    logic   mid_done_reg, mid_done_next;

    logic run_mode;
    logic cont;
    logic f_flush, f_chars, f_div, f_cmt, f_mid, scan_c, f_scan_emit, f_eof;

    // what the current word needs, fixed until the word is finished
    always_comb
    begin
        run_mode = st.mode == mcl_pkg::M_ID || st.mode == mcl_pkg::M_NUM;
        cont     = (st.mode == mcl_pkg::M_ID && st.cls == mcl_pkg::C_LETTER) ||
                   (st.mode == mcl_pkg::M_NUM && st.cls == mcl_pkg::C_DIGIT);
        f_flush  = run_mode && (st.end_flag || !cont);
        f_chars  = f_flush && (st.flush_code == mcl_pkg::TOK_ID ||
                               st.flush_code == mcl_pkg::TOK_NUM);
        f_div    = st.mode == mcl_pkg::M_SLASH &&
                   (st.end_flag || st.cls != mcl_pkg::C_STAR);
        f_cmt    = st.mode == mcl_pkg::M_STAR && !st.end_flag &&
                   st.cls == mcl_pkg::C_SLASH;
        f_mid    = f_div || f_cmt;
        scan_c   = !st.end_flag && (st.mode == mcl_pkg::M_START || f_flush || f_div);
        f_scan_emit = scan_c && (st.cls == mcl_pkg::C_STAR || st.cls == mcl_pkg::C_OP ||
                                 st.cls == mcl_pkg::C_OTHER);
        f_eof    = st.end_flag;
    end

    always_comb
    begin
        state_next      = state_reg;
        flush_done_next = flush_done_reg;
        mid_done_next   = mid_done_reg;
        cmd             = '0;
        cmd.emit_kind   = mcl_pkg::REC_TOKEN;
        case (state_reg)
            S_IDLE:
            begin
                if (src_valid)
                begin
                    cmd.load_in     = 1'b1;
                    flush_done_next = 1'b0;
                    mid_done_next   = 1'b0;
                    state_next      = S_WORK;
                end
            end
            S_WORK:
            begin
                if (f_flush && !flush_done_reg)
                begin
                    if (st.out_free)
                    begin
                        cmd.emit          = 1'b1;
                        cmd.emit_code     = st.flush_code;
                        cmd.emit_run_last = !f_chars && !f_scan_emit && !f_eof;
                        cmd.idx_clr       = 1'b1;
                        flush_done_next   = 1'b1;
                        if (f_chars)
                            state_next = S_RDREQ;
                    end
                end
                else if (f_mid && !mid_done_reg)
                begin
                    if (st.out_free)
                    begin
                        cmd.emit          = 1'b1;
                        cmd.emit_code     = f_div ? mcl_pkg::TOK_DIV : mcl_pkg::TOK_COMMENT;
                        cmd.emit_run_last = !f_scan_emit && !f_eof;
                        mid_done_next     = 1'b1;
                    end
                end
                else if (f_scan_emit)
                begin
                    if (st.out_free)
                    begin
                        cmd.emit          = 1'b1;
                        cmd.emit_code     = st.scan_code;
                        cmd.emit_run_last = 1'b1;
                        cmd.finish        = 1'b1;
                        cmd.scan          = 1'b1;
                        state_next        = S_IDLE;
                    end
                end
                else if (f_eof)
                begin
                    if (st.out_free)
                    begin
                        cmd.emit          = 1'b1;
                        cmd.emit_code     = mcl_pkg::TOK_EOF;
                        cmd.emit_run_last = 1'b1;
                        cmd.clear         = 1'b1;
                        state_next        = S_IDLE;
                    end
                end
                else
                begin
                    cmd.finish = 1'b1;
                    cmd.scan   = scan_c;
                    state_next = S_IDLE;
                end
            end
            S_RDREQ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHAR;
            end
            S_CHAR:
            begin
                if (st.out_free)
                begin
                    cmd.emit          = 1'b1;
                    cmd.emit_kind     = mcl_pkg::REC_CHAR;
                    cmd.emit_code     = st.flush_code;
                    cmd.emit_run_last = st.char_last && !f_scan_emit && !f_eof;
                    cmd.idx_inc       = 1'b1;
                    state_next        = st.char_last ? S_WORK : S_RDREQ;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            stall_reg      <= 1'b0;
            flush_done_reg <= 1'b0;
            mid_done_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            stall_reg      <= state_next != S_IDLE;
            flush_done_reg <= flush_done_next;
            mid_done_reg   <= mid_done_next;
        end
    end

    assign src_stall = stall_reg;

    a_stall_state: assert property (@(posedge clk) disable iff (!rst_n)
        stall_reg == (state_reg != S_IDLE))
        else $error("intake stall out of step with controller state");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.out_free)
        else $error("record written over an untaken word");

    a_char_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHAR |-> ($past(state_reg) == S_RDREQ || $past(state_reg) == S_CHAR))
        else $error("character record without a memory read");

endmodule

[rtl/core/mini_c_lexer.sv]
// Top level of the mini C lexer: controller plus datapath.
//
//  channel  | dir | payload              | handshake
//  ---------+-----+----------------------+-----------------------------
//  src      | in  | in_word_t  (9 bits)  | src_valid / src_stall
//  tok      | out | out_word_t (32 bits) | tok_valid / tok_stall
//
// A word is first loaded; a run token or a slash/comment token record may follow,
// each lexeme character record needs a registered memory read, and an operator,
// error or end-of-file record is written as the word finishes. Output stalls hold records back.
// Reset is asynchronous; afterwards the block is in start mode on line 1.
// The output register lets one record wait while the next one is prepared.
module mini_c_lexer #(
    parameter int LEXEME_BUFFER = mcl_pkg::LEXEME_BUFFER_DEF,
    parameter int LINE_BITS     = mcl_pkg::LINE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  mcl_pkg::in_word_t  src_word,
    output logic               tok_valid,
    input  logic               tok_stall,
    output mcl_pkg::out_word_t tok_word
);

    mcl_pkg::cmd_t    cmd;
    mcl_pkg::status_t st;

    mcl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .st        (st),
        .cmd       (cmd)
    );

    mcl_dpath #(
        .LEXEME_BUFFER (LEXEME_BUFFER),
        .LINE_BITS     (LINE_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_word  (src_word),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_word  (tok_word),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
